>>> design/assert_macros.svh
// Assertion helper macros used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Check an implication in the cycle after the condition.
`define CHK_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/dldr_pkg.sv
// ----------------------------------------------------------------------------
// dldr_pkg
// Shared constants, opcodes and types of the deadlock detect and resolve unit.
// ----------------------------------------------------------------------------
package dldr_pkg;

  localparam int NUM_THREADS   = 8;
  localparam int NUM_RESOURCES = 4;
  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int SUMW = 8 + RW + 1;
  localparam logic [9:0] WORK_MAX = 10'd1023;

  typedef enum logic [1:0] {
    OP_WR_FREE = 2'd0,
    OP_WR_HELD = 2'd1,
    OP_WR_NEED = 2'd2,
    OP_DETECT  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,     // load work vector, scan for empty holders
    ST_SCAN,     // test one thread per cycle
    ST_ROUND,    // decide after a full pass
    ST_PICK,     // visit one thread per cycle, compare deadlocked ones
    ST_FREE,     // free victim, one resource per cycle
    ST_EMIT,
    ST_FINAL
  } state_t;

  // Shared unit commands from sequencer
  typedef struct packed {
    logic           init;
    logic           test;     // test thread sel for fit, release if fits
    logic           sum;      // compare held sum of thread sel with best
    logic           free;     // release victim resource
    logic [TW-1:0]  thr;
    logic [RW-1:0]  res;
  } dp_cmd_t;

  typedef struct packed {
    logic           fits;     // last test released thread
    logic [NUM_THREADS-1:0] unfinished;
    logic [TW-1:0]  victim;
  } dp_stat_t;

endpackage

>>> design/deadlock_detect_and_resolve_unit.sv
// Deadlock detector and resolver for 8 threads over 4 resource types. Write
// beats (op 0..2) go straight into the tables. A detect beat runs rounds on
// one shared fit-test/add unit: each round loads the work vector and sweeps
// the thread table one thread per cycle until a pass finishes nobody (up to
// 9 passes). A deadlocked round then sums held counts one thread per cycle
// and frees the victim one resource per cycle before its result beat.
// ----------------------------------------------------------------------------
// deadlock_detect_and_resolve_unit
// Top level: sequencer plus table datapath.
// ----------------------------------------------------------------------------
module deadlock_detect_and_resolve_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [2:0] thread_sel,
  input  logic [1:0] resource_sel,
  input  logic [7:0] amount,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [2:0] victim,
  output logic [7:0] deadlocked_set,
  output logic       any_deadlock,
  output logic       last
);
  import dldr_pkg::*;

  logic      victim_policy;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      wr_en;

  // Hold policy register
  always_ff @(posedge clk) begin
    if (rst) victim_policy <= 1'b0;
    else if (cfg_we) victim_policy <= cfg_wdata;
  end

  dldr_seq u_seq (
    .clk, .rst, .in_valid, .in_ready, .in_op(op_t'(op)), .stat, .cmd, .wr_en,
    .out_valid, .out_ready, .kind, .victim, .deadlocked_set, .any_deadlock, .last
  );

  dldr_datapath u_dp (
    .clk, .rst, .wr_en, .wr_op(op_t'(op)), .wr_thr(thread_sel), .wr_res(resource_sel),
    .wr_amt(amount), .policy(victim_policy), .cmd, .stat
  );

endmodule

>>> design/dldr_datapath.sv
// ----------------------------------------------------------------------------
// dldr_datapath
// Tables, work vector and the shared compare/add unit of the detector.
// ----------------------------------------------------------------------------
module dldr_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  dldr_pkg::op_t          wr_op,
  input  logic [2:0]             wr_thr,
  input  logic [1:0]             wr_res,
  input  logic [7:0]             wr_amt,
  input  logic                   policy,
  input  dldr_pkg::dp_cmd_t      cmd,
  output dldr_pkg::dp_stat_t     stat
);
  import dldr_pkg::*;

  logic [7:0] free_count   [NUM_RESOURCES];
  logic [7:0] held_count   [NUM_THREADS][NUM_RESOURCES];
  logic [7:0] needed_count [NUM_THREADS][NUM_RESOURCES];
  logic [9:0] work_vector  [NUM_RESOURCES];
  logic [NUM_THREADS-1:0] finished;
  logic            fits;
  logic [SUMW-1:0] best_sum;
  logic            have;
  logic [TW-1:0]   best;

  // Selected thread fit and sum, victim compare, empty holders, index checks
  logic            fit_c;
  logic            nothing [NUM_THREADS];
  logic [SUMW-1:0] sum_c;
  logic            better;
  logic            wr_thr_ok;
  logic            wr_res_ok;

  always_comb begin
    fit_c = 1'b1;
    sum_c = '0;
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      if ({2'b00, needed_count[cmd.thr][r]} > work_vector[r]) fit_c = 1'b0;
      sum_c = sum_c + SUMW'(held_count[cmd.thr][r]);
    end
    for (int t = 0; t < NUM_THREADS; t++) begin
      nothing[t] = 1'b1;
      for (int r = 0; r < NUM_RESOURCES; r++)
        if (held_count[t][r] != 8'd0) nothing[t] = 1'b0;
    end
    better = !have || (policy ? (sum_c <= best_sum) : (sum_c >= best_sum));
    wr_thr_ok = ({29'd0, wr_thr} < 32'(NUM_THREADS));
    wr_res_ok = ({30'd0, wr_res} < 32'(NUM_RESOURCES));
  end

  // Tables: writes from input beats, victim release from sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        free_count[r] <= '0;
        for (int t = 0; t < NUM_THREADS; t++) begin
          held_count[t][r]   <= '0;
          needed_count[t][r] <= '0;
        end
      end
    end else if (wr_en) begin
      unique case (wr_op)
        OP_WR_FREE: if (wr_res_ok) free_count[wr_res[RW-1:0]] <= wr_amt;
        OP_WR_HELD:
          if (wr_thr_ok && wr_res_ok)
            held_count[wr_thr[TW-1:0]][wr_res[RW-1:0]] <= wr_amt;
        OP_WR_NEED:
          if (wr_thr_ok && wr_res_ok)
            needed_count[wr_thr[TW-1:0]][wr_res[RW-1:0]] <= wr_amt;
        default: ;
      endcase
    end else if (cmd.free) begin
      if ({1'b0, free_count[cmd.res]} + {1'b0, held_count[best][cmd.res]} > 9'd255)
        free_count[cmd.res] <= 8'd255;
      else
        free_count[cmd.res] <= free_count[cmd.res] + held_count[best][cmd.res];
      held_count[best][cmd.res]   <= '0;
      needed_count[best][cmd.res] <= '0;
    end
  end

  // Work vector, finished mask and victim search
  always_ff @(posedge clk) begin
    if (rst) begin
      fits <= 1'b0;
      have <= 1'b0;
      best <= '0;
    end else if (cmd.init) begin
      for (int r = 0; r < NUM_RESOURCES; r++) work_vector[r] <= {2'b00, free_count[r]};
      for (int t = 0; t < NUM_THREADS; t++) finished[t] <= nothing[t];
      fits <= 1'b0;
      have <= 1'b0;
    end else if (cmd.test) begin
      fits <= 1'b0;
      if (!finished[cmd.thr] && fit_c) begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
          if (work_vector[r] + {2'b00, held_count[cmd.thr][r]} > {1'b0, WORK_MAX})
            work_vector[r] <= WORK_MAX;
          else
            work_vector[r] <= work_vector[r] + {2'b00, held_count[cmd.thr][r]};
        end
        finished[cmd.thr] <= 1'b1;
        fits <= 1'b1;
      end
    end else if (cmd.sum) begin
      if (!finished[cmd.thr] && better) begin
        best     <= cmd.thr;
        best_sum <= sum_c;
        have     <= 1'b1;
      end
    end
  end

  assign stat.fits       = fits;
  assign stat.unfinished = ~finished;
  assign stat.victim     = best;

endmodule

>>> design/dldr_seq.sv
// ----------------------------------------------------------------------------
// dldr_seq
// Sequencer: drives detection rounds, victim search and release, emits beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dldr_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dldr_pkg::op_t       in_op,
  input  dldr_pkg::dp_stat_t  stat,
  output dldr_pkg::dp_cmd_t   cmd,
  output logic                wr_en,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [2:0]          victim,
  output logic [7:0]          deadlocked_set,
  output logic                any_deadlock,
  output logic                last
);
  import dldr_pkg::*;

  state_t state, state_next;
  logic [TW-1:0] idx, idx_next;
  logic [RW-1:0] ridx, ridx_next;
  logic progress, progress_next;
  logic any, any_next;
  logic [NUM_THREADS-1:0] dead, dead_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      ridx <= '0;
      progress <= 1'b0;
      any <= 1'b0;
      dead <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      ridx <= ridx_next;
      progress <= progress_next;
      any <= any_next;
      dead <= dead_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    idx_next = idx;
    ridx_next = ridx;
    progress_next = progress;
    any_next = any;
    dead_next = dead;
    cmd = '0;
    cmd.thr = idx;
    cmd.res = ridx;
    in_ready = 1'b0;
    wr_en = 1'b0;
    out_valid = 1'b0;
    kind = 1'b0;
    victim = '0;
    deadlocked_set = '0;
    any_deadlock = any;
    last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_DETECT) begin
            any_next = 1'b0;
            state_next = ST_INIT;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        idx_next = '0;
        progress_next = 1'b0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        // stat.fits reflects the thread tested last cycle; at the start of a
        // pass it belongs to the previous pass and was already counted
        cmd.test = 1'b1;
        if (32'(idx) == NUM_THREADS - 1) begin
          state_next = ST_ROUND;
        end
        idx_next = (32'(idx) == NUM_THREADS - 1) ? '0 : idx + 1'b1;
        if (stat.fits && idx != '0) progress_next = 1'b1;
      end
      ST_ROUND: begin
        // Rescan while any thread finished during the pass
        if (progress || stat.fits) begin
          progress_next = 1'b0;
          idx_next = '0;
          state_next = ST_SCAN;
        end else if (stat.unfinished == '0) begin
          state_next = ST_FINAL;
        end else begin
          dead_next = stat.unfinished;
          idx_next = '0;
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.sum = 1'b1;
        idx_next = idx + 1'b1;
        if (32'(idx) == NUM_THREADS - 1) begin
          ridx_next = '0;
          state_next = ST_FREE;
        end
      end
      ST_FREE: begin
        cmd.free = 1'b1;
        ridx_next = ridx + 1'b1;
        if (32'(ridx) == NUM_RESOURCES - 1) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        victim = 3'(stat.victim);
        deadlocked_set = 8'(dead);
        any_deadlock = 1'b1;
        if (out_ready) begin
          any_next = 1'b1;
          state_next = ST_INIT;
        end
      end
      ST_FINAL: begin
        out_valid = 1'b1;
        kind = 1'b1;
        last = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CHK_IMPLY(a_ready_idle, clk, rst, in_ready, state == ST_IDLE, "ready outside idle")
  `CHK_IMPLY(a_last_kind, clk, rst, out_valid, last == kind, "last and kind differ")
  `CHK_NEXT(a_emit_any, clk, rst, out_valid && out_ready && !last, any, "victim not recorded")

endmodule

>>> tb/deadlock_detect_and_resolve_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadlock_detect_and_resolve_unit_tb
// Drives table writes and detect beats into the deadlock unit, predicts every
// victim and final beat from a local copy of the tables, and compares each
// output beat field by field, with random idles and stalls in most tests.
// ----------------------------------------------------------------------------
module deadlock_detect_and_resolve_unit_tb;
  import dldr_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [2:0] victim;
    logic [7:0] deadlocked_set;
    logic       any_deadlock;
    logic       last;
  } verdict_t;

  localparam int CYCLE_LIMIT = 2000000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] op;
  logic [2:0] thread_sel;
  logic [1:0] resource_sel;
  logic [7:0] amount;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [2:0] victim;
  logic [7:0] deadlocked_set;
  logic       any_deadlock;
  logic       last;

  // Predictor state
  logic       policy_q;
  logic [7:0] avail_q [NUM_RESOURCES];
  logic [7:0] alloc_q [NUM_THREADS][NUM_RESOURCES];
  logic [7:0] claim_q [NUM_THREADS][NUM_RESOURCES];

  verdict_t   pending_beats [$];
  int         error_count;
  int         cycle_count;
  bit         send_idle_en;
  bit         recv_idle_en;
  int         hold_off_cycles;
  int         detect_count;

  deadlock_detect_and_resolve_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .thread_sel(thread_sel), .resource_sel(resource_sel), .amount(amount),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .victim(victim), .deadlocked_set(deadlocked_set),
    .any_deadlock(any_deadlock), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("ERROR t=%0t %s got=%0d want=%0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Run one detection round; return the unfinished mask
  function automatic logic [NUM_THREADS-1:0] unfinished_threads();
    logic [9:0] pool [NUM_RESOURCES];
    logic [NUM_THREADS-1:0] done;
    logic [10:0] s;
    bit moved, idle, fit;
    for (int r = 0; r < NUM_RESOURCES; r++) pool[r] = {2'b0, avail_q[r]};
    done = '0;
    for (int t = 0; t < NUM_THREADS; t++) begin
      idle = 1;
      for (int r = 0; r < NUM_RESOURCES; r++) if (alloc_q[t][r] != 0) idle = 0;
      done[t] = idle;
    end
    moved = 1;
    while (moved) begin
      moved = 0;
      for (int t = 0; t < NUM_THREADS && !moved; t++) begin
        if (done[t]) continue;
        fit = 1;
        for (int r = 0; r < NUM_RESOURCES; r++)
          if ({2'b0, claim_q[t][r]} > pool[r]) fit = 0;
        if (!fit) continue;
        for (int r = 0; r < NUM_RESOURCES; r++) begin
          s = pool[r] + alloc_q[t][r];
          pool[r] = (s > 11'd1023) ? 10'd1023 : s[9:0];
        end
        done[t] = 1;
        moved = 1;
      end
    end
    return ~done;
  endfunction

  // Apply one accepted beat to the predictor, queue its results
  task automatic predict_beat(input op_t o, input logic [2:0] t, input logic [1:0] r,
                              input logic [7:0] a);
    logic [NUM_THREADS-1:0] dead;
    int pick, total, best;
    bit have, any;
    logic [8:0] s;
    verdict_t v;
    case (o)
      OP_WR_FREE: avail_q[r] = a;
      OP_WR_HELD: alloc_q[t][r] = a;
      OP_WR_NEED: claim_q[t][r] = a;
      default: begin
        any = 0;
        for (int k = 0; k < NUM_THREADS; k++) begin
          dead = unfinished_threads();
          if (dead == 0) break;
          have = 0; pick = 0; best = 0;
          for (int i = 0; i < NUM_THREADS; i++) begin
            if (!dead[i]) continue;
            total = 0;
            for (int j = 0; j < NUM_RESOURCES; j++) total += alloc_q[i][j];
            if (!have || (policy_q ? total <= best : total >= best)) begin
              pick = i; best = total; have = 1;
            end
          end
          for (int j = 0; j < NUM_RESOURCES; j++) begin
            s = avail_q[j] + alloc_q[pick][j];
            avail_q[j] = s[8] ? 8'd255 : s[7:0];
            alloc_q[pick][j] = 0;
            claim_q[pick][j] = 0;
          end
          any = 1;
          v = '{1'b0, pick[2:0], dead[7:0], 1'b1, 1'b0};
          pending_beats.push_back(v);
        end
        v = '{1'b1, 3'd0, 8'd0, any, 1'b1};
        pending_beats.push_back(v);
      end
    endcase
  endtask

  // Send one beat and hold it until accepted; drop valid only while idling
  task automatic send_beat(input op_t o, input logic [2:0] t, input logic [1:0] r,
                           input logic [7:0] a);
    while (send_idle_en && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    thread_sel   <= t;
    resource_sel <= r;
    amount       <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(o, t, r, a);
  endtask

  // Drop valid, wait for the block to drain, then let it settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_policy(input logic p);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    policy_q = p;
  endtask

  // Receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_en && $urandom_range(99) < 35);
    end
  end

  // Check each output beat against the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        report("unexpected beat", kind, 0);
      end else begin
        want = pending_beats.pop_front();
        if (kind != want.kind) report("kind", kind, want.kind);
        if (victim != want.victim) report("victim", victim, want.victim);
        if (deadlocked_set != want.deadlocked_set)
          report("deadlocked_set", deadlocked_set, want.deadlocked_set);
        if (any_deadlock != want.any_deadlock)
          report("any_deadlock", any_deadlock, want.any_deadlock);
        if (last != want.last) report("last", last, want.last);
      end
    end
  end

  // Write random held and needed entries for random threads, n_threads times
  task automatic build_scenario(input int n_threads);
    for (int i = 0; i < n_threads; i++) begin
      send_beat(OP_WR_HELD, 3'($urandom_range(7)), 2'($urandom_range(3)),
                8'($urandom_range(1, 255)));
      send_beat(OP_WR_NEED, 3'($urandom_range(7)), 2'($urandom_range(3)),
                8'($urandom_range(255)));
    end
  endtask

  task automatic test_directed();
    // Empty tables: final beat only
    send_beat(OP_DETECT, 3'd0, 2'd0, 8'd0);
    // Two threads deadlocked on each other, with free saturation
    send_beat(OP_WR_FREE, 3'd7, 2'd3, 8'd255);
    send_beat(OP_WR_HELD, 3'd0, 2'd0, 8'd255);
    send_beat(OP_WR_HELD, 3'd0, 2'd3, 8'd10);
    send_beat(OP_WR_NEED, 3'd0, 2'd1, 8'd1);
    send_beat(OP_WR_HELD, 3'd7, 2'd1, 8'd255);
    send_beat(OP_WR_NEED, 3'd7, 2'd0, 8'd1);
    send_beat(OP_DETECT, 3'd5, 2'd2, 8'd170);
    // Tie on held sum goes to the higher index
    send_beat(OP_WR_HELD, 3'd2, 2'd2, 8'd5);
    send_beat(OP_WR_NEED, 3'd2, 2'd2, 8'd255);
    send_beat(OP_WR_HELD, 3'd5, 2'd2, 8'd5);
    send_beat(OP_WR_NEED, 3'd5, 2'd2, 8'd255);
    send_beat(OP_DETECT, 3'd0, 2'd0, 8'd0);
    // Work vector saturation: holders release heavily into the pool
    for (int t = 0; t < 8; t++) send_beat(OP_WR_HELD, 3'(t), 2'd1, 8'd200);
    send_beat(OP_WR_NEED, 3'd6, 2'd1, 8'd255);
    send_beat(OP_DETECT, 3'd0, 2'd0, 8'd0);
  endtask

  task automatic test_policy(input logic p, input int rounds);
    set_policy(p);
    for (int k = 0; k < rounds; k++) begin
      build_scenario($urandom_range(2, 10));
      if ($urandom_range(3) == 0)
        send_beat(OP_WR_FREE, 3'($urandom_range(7)), 2'($urandom_range(3)),
                  8'($urandom_range(3) == 0 ? 255 : $urandom_range(4)));
      send_beat(OP_DETECT, 3'($urandom_range(7)), 2'($urandom_range(3)),
                8'($urandom_range(255)));
    end
  endtask

  task automatic test_backpressure();
    drain();
    recv_idle_en = 0;
    send_idle_en = 0;
    hold_off_cycles <= 600;
    for (int k = 0; k < 6; k++) begin
      build_scenario(3);
      send_beat(OP_DETECT, 3'd0, 2'd0, 8'd0);
    end
    send_idle_en = 1;
    recv_idle_en = 1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_wdata = 1'b0;
    in_valid = 1'b0; op = OP_WR_FREE; thread_sel = '0; resource_sel = '0;
    amount = '0; out_ready = 1'b0;
    error_count = 0; cycle_count = 0; hold_off_cycles = 0;
    send_idle_en = 1; recv_idle_en = 1;
    policy_q = 1'b0;
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      avail_q[r] = 0;
      for (int t = 0; t < NUM_THREADS; t++) begin
        alloc_q[t][r] = 0; claim_q[t][r] = 0;
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_policy(1'b1, 5);
    test_policy(1'b0, 5);
    // Long run without idling
    send_idle_en = 0; recv_idle_en = 0;
    test_policy(1'b1, 4);
    send_idle_en = 1; recv_idle_en = 1;
    test_backpressure();
    test_policy(1'b0, 2);
    drain();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/dldr_pkg.sv
design/dldr_datapath.sv
design/dldr_seq.sv
design/deadlock_detect_and_resolve_unit.sv
tb/deadlock_detect_and_resolve_unit_tb.sv
